// File: rtl/uftd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uftd_pkg
// Shared types and constants for the UART receive frame terminator detector.
// ----------------------------------------------------------------------------
package uftd_pkg;

    localparam int BUFFER_DEPTH = 1024;
    localparam int MAX_SEQ_LEN  = 8;
    localparam int COUNT_W      = 10;
    localparam int SEQ_LEN_W    = 4;
    localparam int CFG_IDX_W    = 3;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BUFFER_DEPTH - 1);

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_FA = 8'hFA;

    localparam logic [CFG_IDX_W-1:0] CFG_TERM_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_BYTE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_BYTES   = 3'd4;

    typedef enum logic [2:0] {
        MODE_LF     = 3'd0,
        MODE_CR     = 3'd1,
        MODE_CRLF   = 3'd2,
        MODE_CUSTOM = 3'd3,
        MODE_FAFA   = 3'd4,
        MODE_COUNT  = 3'd5,
        MODE_NONE   = 3'd6,
        MODE_SEQ    = 3'd7
    } t_mode;

    typedef struct packed {
        t_mode                      term_mode;
        logic [7:0]                 term_byte;
        logic [COUNT_W-1:0]         frame_byte_count;
        logic [SEQ_LEN_W-1:0]       seq_length;
        logic [8*MAX_SEQ_LEN-1:0]   seq_bytes;
    } t_cfg;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic [COUNT_W-1:0] frame_position;
        logic               frame_end;
        logic               overflow;
        logic [COUNT_W-1:0] frame_length;
    } t_result;

endpackage

// File: rtl/uftd_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uftd_match
// Terminator test for one byte against the frame count and byte history.
// ----------------------------------------------------------------------------
module uftd_match (
    input  uftd_pkg::t_cfg                  i_cfg,
    input  logic [uftd_pkg::COUNT_W-1:0]    i_frame_count,
    input  logic [7:0]                      i_hist [0:uftd_pkg::MAX_SEQ_LEN-1],
    input  logic [7:0]                      i_rx_byte,
    output uftd_pkg::t_result               o_result,
    output logic [uftd_pkg::COUNT_W-1:0]    o_next_count,
    output logic                            o_keep
);

    logic [7:0]                         newest [0:uftd_pkg::MAX_SEQ_LEN-1];
    logic [uftd_pkg::COUNT_W-1:0]       len;
    logic                               full;
    logic                               end_hit;
    logic [uftd_pkg::MAX_SEQ_LEN:0]     seq_hit;
    logic [uftd_pkg::SEQ_LEN_W-1:0]     seq_n;
    logic                               seq_ok;

    always_comb begin
        newest[0] = i_rx_byte;
        for (int k = 1; k < uftd_pkg::MAX_SEQ_LEN; k++) begin
            newest[k] = i_hist[k-1];
        end
    end

    assign full = (i_frame_count >= uftd_pkg::FULL_COUNT);
    assign len  = i_frame_count + 1'b1;

    // seq_hit[n]: the newest n bytes equal the first n sequence bytes, oldest first
    always_comb begin
        seq_hit = '1;
        for (int n = 1; n <= uftd_pkg::MAX_SEQ_LEN; n++) begin
            for (int i = 0; i < n; i++) begin
                if (i_cfg.seq_bytes[8*i +: 8] != newest[n-1-i]) begin
                    seq_hit[n] = 1'b0;
                end
            end
        end
    end

    assign seq_n = (i_cfg.seq_length > uftd_pkg::SEQ_LEN_W'(uftd_pkg::MAX_SEQ_LEN))
                 ? uftd_pkg::SEQ_LEN_W'(uftd_pkg::MAX_SEQ_LEN) : i_cfg.seq_length;
    assign seq_ok = (len >= uftd_pkg::COUNT_W'(seq_n)) && seq_hit[seq_n];

    always_comb begin
        unique case (i_cfg.term_mode)
            uftd_pkg::MODE_LF:     end_hit = (i_rx_byte == uftd_pkg::CH_LF);
            uftd_pkg::MODE_CR:     end_hit = (i_rx_byte == uftd_pkg::CH_CR);
            uftd_pkg::MODE_CRLF:   end_hit = (len >= 2) && (i_rx_byte == uftd_pkg::CH_LF)
                                           && (i_hist[0] == uftd_pkg::CH_CR);
            uftd_pkg::MODE_CUSTOM: end_hit = (i_rx_byte == i_cfg.term_byte);
            uftd_pkg::MODE_FAFA:   end_hit = (len >= 2) && (i_rx_byte == uftd_pkg::CH_FA)
                                           && (i_hist[0] == uftd_pkg::CH_FA);
            uftd_pkg::MODE_COUNT:  end_hit = (len >= i_cfg.frame_byte_count);
            uftd_pkg::MODE_NONE:   end_hit = 1'b0;
            uftd_pkg::MODE_SEQ:    end_hit = seq_ok;
            default:               end_hit = 1'b0;
        endcase
    end

    always_comb begin
        o_result.data_byte = i_rx_byte;
        if (full) begin
            o_result.frame_position = '0;
            o_result.frame_end      = 1'b0;
            o_result.overflow       = 1'b1;
            o_result.frame_length   = '0;
            o_next_count            = '0;
            o_keep                  = 1'b0;
        end else begin
            o_result.frame_position = i_frame_count;
            o_result.frame_end      = end_hit;
            o_result.overflow       = 1'b0;
            o_result.frame_length   = len;
            o_next_count            = end_hit ? '0 : len;
            o_keep                  = 1'b1;
        end
    end

endmodule

// File: rtl/uart_rx_frame_terminator_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_frame_terminator_detect
// Frame terminator detector for received UART bytes.
// ----------------------------------------------------------------------------
// Accepts one byte per clock while o_in_stall is low and returns one result
// beat per byte, registered into the result or skid register. The per-byte work
// is a combinational compare and count step against the frame counter and an
// eight-byte history; a two-entry output buffer (result register plus skid
// register) keeps input acceptance going while a result waits downstream, and
// o_in_stall rises only when both entries are occupied. Configuration writes
// are always ready and should be issued only while the block is idle.
module uart_rx_frame_terminator_detect (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_rx_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_data_byte,
    output logic [uftd_pkg::COUNT_W-1:0]        o_frame_position,
    output logic                                o_frame_end,
    output logic                                o_overflow,
    output logic [uftd_pkg::COUNT_W-1:0]        o_frame_length,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [uftd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [8*uftd_pkg::MAX_SEQ_LEN-1:0]  i_cfg_data
);

    uftd_pkg::t_cfg                 r_cfg;
    logic [uftd_pkg::COUNT_W-1:0]   r_frame_count;
    logic [7:0]                     r_hist [0:uftd_pkg::MAX_SEQ_LEN-1];
    uftd_pkg::t_result              r_out;
    uftd_pkg::t_result              r_skid;
    logic                           r_out_valid;
    logic                           r_skid_valid;

    uftd_pkg::t_result              n_result;
    logic [uftd_pkg::COUNT_W-1:0]   n_frame_count;
    logic                           keep;
    logic                           in_beat;
    logic                           out_beat;

    assign in_beat     = i_in_valid && !r_skid_valid;
    assign out_beat    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    uftd_match u_match (
        .i_cfg         (r_cfg),
        .i_frame_count (r_frame_count),
        .i_hist        (r_hist),
        .i_rx_byte     (i_rx_byte),
        .o_result      (n_result),
        .o_next_count  (n_frame_count),
        .o_keep        (keep)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.term_mode        <= uftd_pkg::MODE_LF;
            r_cfg.term_byte        <= uftd_pkg::CH_LF;
            r_cfg.frame_byte_count <= '0;
            r_cfg.seq_length       <= '0;
            r_cfg.seq_bytes        <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                uftd_pkg::CFG_TERM_MODE:   r_cfg.term_mode <= uftd_pkg::t_mode'(i_cfg_data[2:0]);
                uftd_pkg::CFG_TERM_BYTE:   r_cfg.term_byte <= i_cfg_data[7:0];
                uftd_pkg::CFG_FRAME_COUNT: r_cfg.frame_byte_count <=
                                               i_cfg_data[uftd_pkg::COUNT_W-1:0];
                uftd_pkg::CFG_SEQ_LENGTH:  r_cfg.seq_length <=
                                               i_cfg_data[uftd_pkg::SEQ_LEN_W-1:0];
                uftd_pkg::CFG_SEQ_BYTES:   r_cfg.seq_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            for (int k = 0; k < uftd_pkg::MAX_SEQ_LEN; k++) begin
                r_hist[k] <= '0;
            end
        end else if (in_beat) begin
            r_frame_count <= n_frame_count;
            if (keep) begin
                r_hist[0] <= i_rx_byte;
                for (int k = 1; k < uftd_pkg::MAX_SEQ_LEN; k++) begin
                    r_hist[k] <= r_hist[k-1];
                end
            end
        end
    end

    // result register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_beat) begin
            if (!r_out_valid || out_beat) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_beat) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            if (!r_out_valid || out_beat) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end else if (out_beat && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_byte      = r_out.data_byte;
    assign o_frame_position = r_out.frame_position;
    assign o_frame_end      = r_out.frame_end;
    assign o_overflow       = r_out.overflow;
    assign o_frame_length   = r_out.frame_length;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without result entry");

    a_full_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (r_frame_count >= uftd_pkg::FULL_COUNT) |=> (r_frame_count == '0))
        else $error("frame count not restarted on full buffer");

    a_overflow_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.overflow |-> !r_out.frame_end && (r_out.frame_length == '0))
        else $error("overflow beat carries frame data");

    a_length_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.overflow |->
            (r_out.frame_length == r_out.frame_position + 1'b1))
        else $error("frame length and position disagree");

endmodule
